@@ rtl/core/iet_pkg.sv @@
// Shared types and constants of the incremental entropy tracker.
`timescale 1ns / 1ps
package iet_pkg;

   localparam int SYMBOL_WIDTH  = 8;
   localparam int ADD_WIDTH     = 16;
   localparam int ENTROPY_WIDTH = 20;
   localparam int MANT_WIDTH    = 32;

   localparam logic [ENTROPY_WIDTH-1:0] ENTROPY_MAX = '1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SETUP,
      ST_LOG,
      ST_MUL,
      ST_DIFF,
      ST_DIV,
      ST_FINISH
   } iet_state_type;

   typedef enum logic [1:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_SQR
   } iet_log_phase_type;

   typedef enum logic [1:0] {
      STEP_FIRST,
      STEP_SECOND,
      STEP_THIRD,
      STEP_LAST
   } iet_step_type;

endpackage

@@ rtl/core/iet_log2.sv @@
// Fixed-point log2 unit: serial normalise, then one mantissa squaring per cycle.
`timescale 1ns / 1ps
module iet_log2 #(
   parameter int COUNT_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [COUNT_WIDTH-1:0]                        operand,
   output logic                                          done,
   output logic [$clog2(COUNT_WIDTH)+FRACTION_BITS-1:0]  result
);
   import iet_pkg::*;

   localparam int EW = $clog2(COUNT_WIDTH);
   localparam int SW = $clog2(FRACTION_BITS);

   iet_log_phase_type phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]            norm_ff, norm_in;
   logic [EW-1:0]                     exp_ff, exp_in;
   logic [MANT_WIDTH-1:0]             mant_ff, mant_in;
   logic [FRACTION_BITS-1:0]          frac_ff, frac_in;
   logic [SW-1:0]                     step_ff, step_in;
   logic                              done_ff, done_in;
   logic [2*MANT_WIDTH-1:0]           square;
   logic [MANT_WIDTH:0]               scaled;
   logic [COUNT_WIDTH+MANT_WIDTH-1:0] padded;

   assign square = mant_ff * mant_ff;
   assign scaled = square[2*MANT_WIDTH-1:MANT_WIDTH-1];
   assign padded = {norm_ff, {MANT_WIDTH{1'b0}}};

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         LOG_IDLE: begin
            if (start && (operand != '0)) phase_in = LOG_NORM;
         end
         LOG_NORM: begin
            if (norm_ff[COUNT_WIDTH-1]) phase_in = LOG_SQR;
         end
         LOG_SQR: begin
            if (step_ff == SW'(FRACTION_BITS - 1)) phase_in = LOG_IDLE;
         end
         default: phase_in = LOG_IDLE;
      endcase
   end

   always_comb begin
      norm_in = norm_ff;
      exp_in  = exp_ff;
      mant_in = mant_ff;
      frac_in = frac_ff;
      step_in = step_ff;
      done_in = 1'b0;
      case (phase_ff)
         LOG_IDLE: begin
            if (start) begin
               norm_in = operand;
               exp_in  = EW'(COUNT_WIDTH - 1);
               frac_in = '0;
               step_in = '0;
               if (operand == '0) begin
                  exp_in  = '0;
                  done_in = 1'b1;
               end
            end
         end
         LOG_NORM: begin
            if (norm_ff[COUNT_WIDTH-1]) begin
               mant_in = padded[COUNT_WIDTH+MANT_WIDTH-1:COUNT_WIDTH];
            end else begin
               norm_in = norm_ff << 1;
               exp_in  = exp_ff - 1'b1;
            end
         end
         LOG_SQR: begin
            frac_in = {frac_ff[FRACTION_BITS-2:0], scaled[MANT_WIDTH]};
            mant_in = scaled[MANT_WIDTH] ? scaled[MANT_WIDTH:1] : scaled[MANT_WIDTH-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(FRACTION_BITS - 1)) done_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= LOG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      norm_ff <= norm_in;
      exp_ff  <= exp_in;
      mant_ff <= mant_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   always_comb begin
      done   = done_ff;
      result = {exp_ff, frac_ff};
   end

endmodule

@@ rtl/core/iet_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module iet_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_WIDTH-1:0]         multiplicand,
   input  logic [B_WIDTH-1:0]         multiplier,
   output logic                       done,
   output logic [A_WIDTH+B_WIDTH-1:0] product
);
   localparam int PW = A_WIDTH + B_WIDTH;
   localparam int NW = $clog2(B_WIDTH + 1);

   logic [PW-1:0]      a_ff, a_in;
   logic [B_WIDTH-1:0] b_ff, b_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (b_ff[0]) prod_in = prod_ff + a_ff;
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         a_in    = PW'(multiplicand);
         b_in    = multiplier;
         prod_in = '0;
         cnt_in  = NW'(B_WIDTH);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

@@ rtl/core/iet_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module iet_div #(
   parameter int N_WIDTH = 55,
   parameter int D_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [N_WIDTH-1:0] dividend,
   input  logic [D_WIDTH-1:0] divisor,
   output logic               done,
   output logic [N_WIDTH-1:0] quotient
);
   localparam int NW = $clog2(N_WIDTH + 1);

   logic [D_WIDTH-1:0] rem_ff, rem_in;
   logic [N_WIDTH-1:0] quo_ff, quo_in;
   logic [D_WIDTH-1:0] dvs_ff, dvs_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [D_WIDTH:0]   trial;
   logic [D_WIDTH:0]   diff;
   logic               fits;

   assign trial = {rem_ff, quo_ff[N_WIDTH-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in = fits ? diff[D_WIDTH-1:0] : trial[D_WIDTH-1:0];
         quo_in = {quo_ff[N_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = NW'(N_WIDTH);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/incremental_entropy_tracker_unit.sv @@
// Top level of the incremental entropy tracker: count table, sequencer and datapath.
`timescale 1ns / 1ps
// Usage
//   req_ channel: one item per (start_run, symbol, added_count); start_run high
//   clears the count table, total and entropy before the item is applied.
//   rsp_ channel: one item per request, the running entropy in bits (Q4.16 for
//   the default FRACTION_BITS) and a flag that a count or the total saturated.
//   Both channels use valid/ready; an item moves when both are high.
// Sequencing
//   One item at a time; the next is taken once the last one finishes. An item
//   takes four serial log2 runs (normalise one bit a cycle, then one squaring
//   a cycle), four bit-serial multiplies of MW bits and a restoring divide of
//   TW bits. An item whose earlier total is zero, or whose symbol lies outside
//   the table, skips all of these and goes straight to its finish.
//   A start_run item first sweeps the table to clear it.
// Reset
//   After reset the block clears the count table, one entry a cycle, and
//   takes no item until that pass ends.
// Stalls
//   A result waits in the output register; the next item is taken meanwhile
//   and only its finish waits until the register is free.
module incremental_entropy_tracker_unit #(
   parameter int SYMBOL_COUNT  = 256,
   parameter int COUNT_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_start_run,
   input  logic [iet_pkg::SYMBOL_WIDTH-1:0]   req_symbol,
   input  logic [iet_pkg::ADD_WIDTH-1:0]      req_added_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [iet_pkg::ENTROPY_WIDTH-1:0]  rsp_entropy_bits,
   output logic                               rsp_count_saturated
);
   import iet_pkg::*;

   localparam int CW  = COUNT_WIDTH;
   localparam int AW  = $clog2(SYMBOL_COUNT);
   localparam int XW  = (AW > SYMBOL_WIDTH) ? AW : SYMBOL_WIDTH;
   localparam int EW  = $clog2(COUNT_WIDTH);
   localparam int LW  = EW + FRACTION_BITS;
   localparam int MW  = (LW > ENTROPY_WIDTH) ? LW : ENTROPY_WIDTH;
   localparam int PRW = CW + MW;
   localparam int PW  = PRW + 1;
   localparam int TW  = PW + 1;

   // sequencer
   iet_state_type state_ff, state_in;
   iet_step_type  step_ff, step_in;
   logic          go_ff, go_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] clr_ff, clr_in;

   // held item and run state
   logic [SYMBOL_WIDTH-1:0]  sym_ff, sym_in;
   logic [ADD_WIDTH-1:0]     add_ff, add_in;
   logic [CW-1:0]            total_ff, total_in;
   logic [ENTROPY_WIDTH-1:0] ent_ff, ent_in;

   // per-item working registers
   logic [CW-1:0]            c_old_ff, c_old_in;
   logic [CW-1:0]            c_new_ff, c_new_in;
   logic [CW-1:0]            n_new_ff, n_new_in;
   logic                     sat_ff, sat_in;
   logic                     upd_ff, upd_in;
   logic [ENTROPY_WIDTH-1:0] res_ff, res_in;
   logic [LW-1:0]            ln_new_ff, ln_new_in;
   logic [LW-1:0]            ln_old_ff, ln_old_in;
   logic [LW-1:0]            lc_new_ff, lc_new_in;
   logic [LW-1:0]            lc_old_ff, lc_old_in;
   logic [PW-1:0]            p_ff, p_in;
   logic [PW-1:0]            q_ff, q_in;
   logic [PW-1:0]            t_ff, t_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ENTROPY_WIDTH-1:0] rsp_ent_ff, rsp_ent_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   // count table
   logic [CW-1:0] count_mem [SYMBOL_COUNT];
   logic [CW-1:0] rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [CW-1:0] mem_wdata;

   // unit hookup
   logic          log_start, log_done;
   logic [CW-1:0] log_operand;
   logic [LW-1:0] log_result;
   logic          mul_start, mul_done;
   logic [CW-1:0] mul_a;
   logic [MW-1:0] mul_b;
   logic [PRW-1:0] mul_prod;
   logic          div_start, div_done;
   logic [TW-1:0] div_dividend;
   logic [TW-1:0] div_quotient;

   logic              accept;
   logic              out_free;
   logic              out_load;
   logic              in_range;
   logic [XW-1:0]     sym_ext;
   logic [CW:0]       n_sum;
   logic [CW:0]       c_sum;
   logic [TW-1:0]     ln_ext;
   logic [TW-1:0]     h_diff;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sym_ext  = XW'(sym_ff);
   assign in_range = 32'(sym_ff) < SYMBOL_COUNT;
   assign n_sum    = {1'b0, total_ff} + (CW+1)'(add_ff);
   assign c_sum    = {1'b0, rd_ff} + (CW+1)'(add_ff);
   assign ln_ext   = TW'(ln_new_ff);
   assign h_diff   = ln_ext - div_quotient;

   // pick the log2 operand and the multiply terms for the current step
   always_comb begin
      case (step_ff)
         STEP_FIRST: begin
            log_operand = n_new_ff;
            mul_a       = total_ff;
            mul_b       = MW'(ln_old_ff);
         end
         STEP_SECOND: begin
            log_operand = total_ff;
            mul_a       = c_new_ff;
            mul_b       = MW'(lc_new_ff);
         end
         STEP_THIRD: begin
            log_operand = c_new_ff;
            mul_a       = total_ff;
            mul_b       = MW'(ent_ff);
         end
         STEP_LAST: begin
            log_operand = c_old_ff;
            mul_a       = c_old_ff;
            mul_b       = MW'(lc_old_ff);
         end
         default: begin
            log_operand = n_new_ff;
            mul_a       = total_ff;
            mul_b       = MW'(ln_old_ff);
         end
      endcase
   end

   // T plus half of N' gives round half up on the divide
   assign div_dividend = TW'(t_ff) + TW'(n_new_ff >> 1);

   iet_log2 #(
      .COUNT_WIDTH   (COUNT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .operand (log_operand),
      .done    (log_done),
      .result  (log_result)
   );

   iet_mul #(
      .A_WIDTH (CW),
      .B_WIDTH (MW)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .done         (mul_done),
      .product      (mul_prod)
   );

   iet_div #(
      .N_WIDTH (TW),
      .D_WIDTH (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_new_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(SYMBOL_COUNT - 1)) state_in = pend_ff ? ST_FETCH : ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = req_start_run ? ST_CLEAR : ST_FETCH;
         end
         ST_FETCH: state_in = ST_SETUP;
         ST_SETUP: begin
            // empty earlier total or foreign symbol: result is known already
            if (!in_range || (total_ff == '0)) state_in = ST_FINISH;
            else state_in = ST_LOG;
         end
         ST_LOG: begin
            if (log_done && (step_ff == STEP_LAST)) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done && (step_ff == STEP_LAST)) state_in = ST_DIFF;
         end
         ST_DIFF: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state-driven controls
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      out_load  = (state_ff == ST_FINISH) && out_free;
      mem_we    = (state_ff == ST_CLEAR) || (out_load && upd_ff);
      mem_addr  = (state_ff == ST_CLEAR) ? clr_ff : sym_ext[AW-1:0];
      mem_wdata = (state_ff == ST_CLEAR) ? '0 : c_new_ff;
      log_start = go_ff && (state_ff == ST_LOG);
      mul_start = go_ff && (state_ff == ST_MUL);
      div_start = go_ff && (state_ff == ST_DIV);
   end

   // datapath next values
   always_comb begin
      step_in      = step_ff;
      go_in        = 1'b0;
      pend_in      = pend_ff;
      clr_in       = clr_ff;
      sym_in       = sym_ff;
      add_in       = add_ff;
      total_in     = total_ff;
      ent_in       = ent_ff;
      c_old_in     = c_old_ff;
      c_new_in     = c_new_ff;
      n_new_in     = n_new_ff;
      sat_in       = sat_ff;
      upd_in       = upd_ff;
      res_in       = res_ff;
      ln_new_in    = ln_new_ff;
      ln_old_in    = ln_old_ff;
      lc_new_in    = lc_new_ff;
      lc_old_in    = lc_old_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(SYMBOL_COUNT - 1)) pend_in = 1'b0;
         end
         ST_IDLE: begin
            if (accept) begin
               sym_in  = req_symbol;
               add_in  = req_added_count;
               pend_in = req_start_run;
               clr_in  = '0;
               if (req_start_run) begin
                  total_in = '0;
                  ent_in   = '0;
               end
            end
         end
         ST_SETUP: begin
            // saturate N' and c', flag either
            n_new_in = n_sum[CW] ? '1 : n_sum[CW-1:0];
            c_new_in = c_sum[CW] ? '1 : c_sum[CW-1:0];
            c_old_in = rd_ff;
            sat_in   = n_sum[CW] || c_sum[CW];
            upd_in   = in_range;
            p_in     = '0;
            q_in     = '0;
            step_in  = STEP_FIRST;
            res_in   = '0;
            if (!in_range) begin
               res_in = ent_ff;
               sat_in = 1'b0;
            end else if (total_ff != '0) begin
               go_in = 1'b1;
            end
         end
         ST_LOG: begin
            if (log_done) begin
               case (step_ff)
                  STEP_FIRST:  ln_new_in = log_result;
                  STEP_SECOND: ln_old_in = log_result;
                  STEP_THIRD:  lc_new_in = log_result;
                  STEP_LAST:   lc_old_in = log_result;
                  default:     ln_new_in = log_result;
               endcase
               step_in = iet_step_type'(step_ff + 2'd1);
               go_in   = 1'b1;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               // first two terms build P, the last two build Q
               if ((step_ff == STEP_FIRST) || (step_ff == STEP_SECOND)) p_in = p_ff + PW'(mul_prod);
               else q_in = q_ff + PW'(mul_prod);
               step_in = iet_step_type'(step_ff + 2'd1);
               if (step_ff != STEP_LAST) go_in = 1'b1;
            end
         end
         ST_DIFF: begin
            t_in  = (p_ff >= q_ff) ? (p_ff - q_ff) : '0;
            go_in = 1'b1;
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_quotient > ln_ext) res_in = '0;
               else if (h_diff > TW'(ENTROPY_MAX)) res_in = ENTROPY_MAX;
               else res_in = h_diff[ENTROPY_WIDTH-1:0];
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ent_in   = res_ff;
               rsp_sat_in   = sat_ff;
               if (upd_ff) begin
                  total_in = n_new_ff;
                  ent_in   = res_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         go_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         total_ff     <= '0;
         ent_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         ent_ff       <= ent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff    <= step_in;
      sym_ff     <= sym_in;
      add_ff     <= add_in;
      c_old_ff   <= c_old_in;
      c_new_ff   <= c_new_in;
      n_new_ff   <= n_new_in;
      sat_ff     <= sat_in;
      upd_ff     <= upd_in;
      res_ff     <= res_in;
      ln_new_ff  <= ln_new_in;
      ln_old_ff  <= ln_old_in;
      lc_new_ff  <= lc_new_in;
      lc_old_ff  <= lc_old_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      t_ff       <= t_in;
      rsp_ent_ff <= rsp_ent_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   // count table: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) count_mem[mem_addr] <= mem_wdata;
      rd_ff <= count_mem[mem_addr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entropy_bits    = rsp_ent_ff;
   assign rsp_count_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item left the sequencer idle");

   a_one_unit_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0({log_done, mul_done, div_done}))
      else $error("two arithmetic units finished together");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      (out_load && upd_ff) |=> (total_ff >= $past(total_ff)))
      else $error("running total shrank within a run");

   a_setup_after_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> ($past(state_ff) == ST_FETCH))
      else $error("setup entered without a table read");
`endif

endmodule
